// File: hw/rtl/fla_pkg.sv
// Shared constants, types and codes of the free list fit allocator.
`default_nettype none
package fla_pkg;
   localparam int FREE_NODES    = 64;
   localparam int GRANT_ENTRIES = 64;
   localparam int MAX_REGIONS   = 256;
   localparam int REGION_BYTES  = 4096;
   localparam int HDR_BYTES     = 16;

   localparam int ADDR_W = 20;
   localparam int SIZE_W = 12;
   localparam int CHAIN_DEPTH = (FREE_NODES > GRANT_ENTRIES) ? FREE_NODES : GRANT_ENTRIES;
   localparam int IDX_W  = $clog2(CHAIN_DEPTH);
   localparam int FLEN_W = $clog2(FREE_NODES + 1);
   localparam int GLEN_W = $clog2(GRANT_ENTRIES + 1);
   localparam int REG_W  = $clog2(MAX_REGIONS + 1);
   localparam int REG_SHIFT = $clog2(REGION_BYTES);

   localparam logic [SIZE_W-1:0] SLOT_MAX = SIZE_W'(REGION_BYTES - HDR_BYTES);
   localparam logic [SIZE_W-1:0] HDR_SIZE = SIZE_W'(HDR_BYTES);

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_REGION = 2'd1;
   localparam logic [1:0] ST_POOL_FULL = 2'd2;
   localparam logic [1:0] ST_UNKNOWN   = 2'd3;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] bytes;
   } slot_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_ROTATE = 2'd1,
      OP_INSERT = 2'd2,
      OP_DELETE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [IDX_W-1:0] k;
   } chain_ctl_type;
endpackage
`default_nettype wire

// File: hw/rtl/fla_ifs.sv
// Request and response channel interfaces.
`default_nettype none
interface fla_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [fla_pkg::SIZE_W-1:0] alloc_bytes;
   logic [fla_pkg::ADDR_W-1:0] release_addr;
   modport source (output valid, req_type, alloc_bytes, release_addr, input ready);
   modport sink (input valid, req_type, alloc_bytes, release_addr, output ready);
endinterface

interface fla_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [fla_pkg::ADDR_W-1:0] object_addr;
   logic [1:0]                status;
   logic                      region_added;
   modport source (output valid, object_addr, status, region_added, input ready);
   modport sink (input valid, object_addr, status, region_added, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/fla_cell.sv
// One slot cell of a shifting list chain.
`default_nettype none
module fla_cell (
   input  wire logic                      clock,
   input  wire fla_pkg::chain_ctl_type    ctl,
   input  wire logic [fla_pkg::IDX_W-1:0] idx,
   input  wire fla_pkg::slot_type         prev_data,
   input  wire fla_pkg::slot_type         next_data,
   input  wire fla_pkg::slot_type         new_data,
   output fla_pkg::slot_type              data
);
   fla_pkg::slot_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         fla_pkg::OP_ROTATE: data_in = next_data;
         fla_pkg::OP_INSERT: begin
            if (idx == '0) data_in = new_data;
            else if (idx <= ctl.k) data_in = prev_data;
         end
         fla_pkg::OP_DELETE: begin
            if (idx >= ctl.k) data_in = next_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule
`default_nettype wire

// File: hw/rtl/fla_chain.sv
// Row of slot cells with the head cell visible.
`default_nettype none
module fla_chain (
   input  wire logic                   clock,
   input  wire fla_pkg::chain_ctl_type ctl,
   input  wire fla_pkg::slot_type      new_data,
   output fla_pkg::slot_type           head
);
   fla_pkg::slot_type cells_w [fla_pkg::CHAIN_DEPTH];

   for (genvar i = 0; i < fla_pkg::CHAIN_DEPTH; i++) begin : g_cell
      fla_pkg::slot_type prev_w, next_w;
      if (i == 0) begin : g_first
         assign prev_w = new_data;
      end else begin : g_mid
         assign prev_w = cells_w[i-1];
      end
      if (i == fla_pkg::CHAIN_DEPTH - 1) begin : g_last
         assign next_w = cells_w[0];
      end else begin : g_inner
         assign next_w = cells_w[i+1];
      end
      fla_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .idx       (fla_pkg::IDX_W'(i)),
         .prev_data (prev_w),
         .next_data (next_w),
         .new_data  (new_data),
         .data      (cells_w[i])
      );
   end

   assign head = cells_w[0];
endmodule
`default_nettype wire

// File: hw/rtl/free_list_fit_allocator_top.sv
// Top level of the free list fit allocator.
// Usage:
//   req_chan carries one request: allocate (alloc_bytes) or free (release_addr).
//   rsp_chan returns exactly one response per request: object_addr, status
//   and region_added. csr_wr_en/csr_wr_data set the fit policy (reset: worst
//   fit); write it only while no request is in flight.
//   Free slots and live objects sit in two rows of cells. For every request
//   both rows rotate once all the way round (one cell per cycle), the control
//   picks the slot and grant entry, then the update step inserts or removes
//   cells. A request is accepted only while idle, so the next request is
//   taken only after the update of the previous one has been applied.
//   The response sits in an output register; a stalled receiver holds it and
//   the next request is scanned, but its update waits until the response
//   register is free.
//   Reset empties both lists, clears the region count and sets worst fit;
//   no clearing pass is needed.
`default_nettype none
module free_list_fit_allocator_top (
   input  wire logic       clock,
   input  wire logic       reset,
   fla_req_if.sink         req_chan,
   fla_rsp_if.source       rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_wr_data
);
   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] policy_ff, policy_in;
   logic [fla_pkg::FLEN_W-1:0] flen_ff, flen_in;
   logic [fla_pkg::GLEN_W-1:0] glen_ff, glen_in;
   logic [fla_pkg::REG_W-1:0]  regions_ff, regions_in;
   logic [fla_pkg::IDX_W-1:0]  cnt_ff, cnt_in;

   logic                        rtype_ff, rtype_in;
   logic [fla_pkg::SIZE_W-1:0]  size_ff, size_in;
   logic [fla_pkg::ADDR_W-1:0]  raddr_ff, raddr_in;

   logic                        found_ff, found_in;
   logic [fla_pkg::IDX_W-1:0]   fk_ff, fk_in;
   logic [fla_pkg::SIZE_W-1:0]  best_ff, best_in;
   logic [fla_pkg::ADDR_W-1:0]  cbase_ff, cbase_in;
   logic                        gfound_ff, gfound_in;
   logic [fla_pkg::IDX_W-1:0]   gk_ff, gk_in;
   logic [fla_pkg::SIZE_W-1:0]  gbytes_ff, gbytes_in;

   logic                        rvalid_ff, rvalid_in;
   logic [fla_pkg::ADDR_W-1:0]  raddr_out_ff, raddr_out_in;
   logic [1:0]                  rstat_ff, rstat_in;
   logic                        rreg_ff, rreg_in;

   fla_pkg::chain_ctl_type fctl, gctl;
   fla_pkg::slot_type      fnew, gnew, fhead, ghead;

   logic                       take, fval, gval, go;
   logic [fla_pkg::ADDR_W-1:0] abase;
   logic [fla_pkg::SIZE_W-1:0] abytes, remain;

   fla_chain u_free (.clock(clock), .ctl(fctl), .new_data(fnew), .head(fhead));
   fla_chain u_grant (.clock(clock), .ctl(gctl), .new_data(gnew), .head(ghead));

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rvalid_ff;
   assign rsp_chan.object_addr  = raddr_out_ff;
   assign rsp_chan.status       = rstat_ff;
   assign rsp_chan.region_added = rreg_ff;

   always_comb begin
      fval = ({1'b0, cnt_ff} < (fla_pkg::IDX_W + 1)'(flen_ff));
      gval = ({1'b0, cnt_ff} < (fla_pkg::IDX_W + 1)'(glen_ff));
      take = 1'b0;
      if (fval && fhead.bytes >= size_ff) begin
         case (policy_ff)
            fla_pkg::FIT_BEST:  take = !found_ff || fhead.bytes < best_ff;
            fla_pkg::FIT_WORST: take = fhead.bytes > best_ff;
            default:            take = !found_ff;
         endcase
      end
      abase  = found_ff ? cbase_ff : fla_pkg::ADDR_W'({regions_ff, {fla_pkg::REG_SHIFT{1'b0}}});
      abytes = found_ff ? best_ff : fla_pkg::SLOT_MAX;
      remain = abytes - size_ff;
      go     = !rvalid_ff || rsp_chan.ready;
   end

   always_comb begin
      state_in     = state_ff;
      policy_in    = csr_wr_en ? csr_wr_data : policy_ff;
      flen_in      = flen_ff;
      glen_in      = glen_ff;
      regions_in   = regions_ff;
      cnt_in       = cnt_ff;
      rtype_in     = rtype_ff;
      size_in      = size_ff;
      raddr_in     = raddr_ff;
      found_in     = found_ff;
      fk_in        = fk_ff;
      best_in      = best_ff;
      cbase_in     = cbase_ff;
      gfound_in    = gfound_ff;
      gk_in        = gk_ff;
      gbytes_in    = gbytes_ff;
      rvalid_in    = rvalid_ff && !rsp_chan.ready;
      raddr_out_in = raddr_out_ff;
      rstat_in     = rstat_ff;
      rreg_in      = rreg_ff;
      fctl.op      = fla_pkg::OP_HOLD;
      fctl.k       = '1;
      gctl.op      = fla_pkg::OP_HOLD;
      gctl.k       = '1;
      fnew.base    = abase + fla_pkg::ADDR_W'(fla_pkg::HDR_BYTES) + fla_pkg::ADDR_W'(size_ff);
      fnew.bytes   = remain - fla_pkg::HDR_SIZE;
      gnew.base    = abase + fla_pkg::ADDR_W'(fla_pkg::HDR_BYTES);
      gnew.bytes   = size_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               rtype_in  = req_chan.req_type;
               size_in   = req_chan.alloc_bytes;
               raddr_in  = req_chan.release_addr;
               found_in  = 1'b0;
               best_in   = '0;
               gfound_in = 1'b0;
               cnt_in    = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            fctl.op = fla_pkg::OP_ROTATE;
            gctl.op = fla_pkg::OP_ROTATE;
            if (take) begin
               found_in = 1'b1;
               fk_in    = cnt_ff;
               best_in  = fhead.bytes;
               cbase_in = fhead.base;
            end
            if (gval && !gfound_ff && ghead.base == raddr_ff) begin
               gfound_in = 1'b1;
               gk_in     = cnt_ff;
               gbytes_in = ghead.bytes;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == fla_pkg::IDX_W'(fla_pkg::CHAIN_DEPTH - 1)) state_in = S_APPLY;
         end
         S_APPLY: begin
            if (go) begin
               state_in     = S_IDLE;
               rvalid_in    = 1'b1;
               raddr_out_in = '0;
               rreg_in      = 1'b0;
               rstat_in     = fla_pkg::ST_OK;
               if (rtype_ff == fla_pkg::REQ_FREE) begin
                  if (!gfound_ff) rstat_in = fla_pkg::ST_UNKNOWN;
                  else if (flen_ff == fla_pkg::FLEN_W'(fla_pkg::FREE_NODES))
                     rstat_in = fla_pkg::ST_POOL_FULL;
                  else begin
                     gctl.op    = fla_pkg::OP_DELETE;
                     gctl.k     = gk_ff;
                     glen_in    = glen_ff - 1'b1;
                     fctl.op    = fla_pkg::OP_INSERT;
                     fnew.base  = raddr_ff - fla_pkg::ADDR_W'(fla_pkg::HDR_BYTES);
                     fnew.bytes = gbytes_ff;
                     flen_in    = flen_ff + 1'b1;
                  end
               end else if (size_ff > fla_pkg::SLOT_MAX) begin
                  rstat_in = fla_pkg::ST_NO_REGION;
               end else if (glen_ff == fla_pkg::GLEN_W'(fla_pkg::GRANT_ENTRIES)) begin
                  rstat_in = fla_pkg::ST_POOL_FULL;
               end else if (!found_ff && regions_ff == fla_pkg::REG_W'(fla_pkg::MAX_REGIONS)) begin
                  rstat_in = fla_pkg::ST_NO_REGION;
               end else if (!found_ff && flen_ff == fla_pkg::FLEN_W'(fla_pkg::FREE_NODES)) begin
                  rstat_in = fla_pkg::ST_POOL_FULL;
               end else begin
                  raddr_out_in = gnew.base;
                  gctl.op      = fla_pkg::OP_INSERT;
                  glen_in      = glen_ff + 1'b1;
                  if (found_ff) begin
                     if (remain > fla_pkg::HDR_SIZE) begin
                        fctl.op = fla_pkg::OP_INSERT;
                        fctl.k  = fk_ff;
                     end else begin
                        fctl.op = fla_pkg::OP_DELETE;
                        fctl.k  = fk_ff;
                        flen_in = flen_ff - 1'b1;
                     end
                  end else begin
                     rreg_in    = 1'b1;
                     regions_in = regions_ff + 1'b1;
                     if (remain > fla_pkg::HDR_SIZE) begin
                        fctl.op = fla_pkg::OP_INSERT;
                        flen_in = flen_ff + 1'b1;
                     end
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         policy_ff  <= fla_pkg::FIT_WORST;
         flen_ff    <= '0;
         glen_ff    <= '0;
         regions_ff <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         policy_ff  <= policy_in;
         flen_ff    <= flen_in;
         glen_ff    <= glen_in;
         regions_ff <= regions_in;
         rvalid_ff  <= rvalid_in;
      end
      cnt_ff       <= cnt_in;
      rtype_ff     <= rtype_in;
      size_ff      <= size_in;
      raddr_ff     <= raddr_in;
      found_ff     <= found_in;
      fk_ff        <= fk_in;
      best_ff      <= best_in;
      cbase_ff     <= cbase_in;
      gfound_ff    <= gfound_in;
      gk_ff        <= gk_in;
      gbytes_ff    <= gbytes_in;
      raddr_out_ff <= raddr_out_in;
      rstat_ff     <= rstat_in;
      rreg_ff      <= rreg_in;
   end

   a_flen_cap: assert property (@(posedge clock) disable iff (reset)
      flen_ff <= fla_pkg::FLEN_W'(fla_pkg::FREE_NODES))
      else $error("free list overfilled");
   a_glen_cap: assert property (@(posedge clock) disable iff (reset)
      glen_ff <= fla_pkg::GLEN_W'(fla_pkg::GRANT_ENTRIES))
      else $error("grant table overfilled");
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> state_ff == S_SCAN)
      else $error("accepted request not scanned");
   a_region_ok: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && rreg_ff |-> rstat_ff == fla_pkg::ST_OK)
      else $error("region taken on failed request");
endmodule
`default_nettype wire

// File: test/free_list_fit_allocator_top_test.sv
// Self-checking testbench of the free list fit allocator: directed and random traffic against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module free_list_fit_allocator_top_test;
   typedef struct packed {
      logic                       kind;
      logic [fla_pkg::SIZE_W-1:0] bytes;
      logic [fla_pkg::ADDR_W-1:0] addr;
   } request_type;

   typedef struct packed {
      logic [fla_pkg::ADDR_W-1:0] addr;
      logic [1:0]                 status;
      logic                       added;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = '0;

   fla_req_if req_chan ();
   fla_rsp_if rsp_chan ();

   free_list_fit_allocator_top dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // allocator mirror
   logic [fla_pkg::ADDR_W-1:0] fl_base [fla_pkg::FREE_NODES];
   logic [fla_pkg::SIZE_W-1:0] fl_bytes [fla_pkg::FREE_NODES];
   int                         fl_link [fla_pkg::FREE_NODES];
   bit                         fl_spare [fla_pkg::FREE_NODES];
   int                         fl_head, fl_len;
   logic [fla_pkg::ADDR_W-1:0] gt_addr [fla_pkg::GRANT_ENTRIES];
   logic [fla_pkg::SIZE_W-1:0] gt_bytes [fla_pkg::GRANT_ENTRIES];
   bit                         gt_valid [fla_pkg::GRANT_ENTRIES];
   int                         regions_taken;
   logic [1:0]                 policy;

   request_type  pending_requests[$];
   response_type awaited_responses[$];
   logic [fla_pkg::ADDR_W-1:0] live_addrs[$];
   int  failures = 0;
   int  idle_cycles = 0;
   int  accepted = 0;
   int  rsp_hold = 0;
   int  req_gap = 0;
   bit  long_hold_done = 0;

   function automatic void mirror_reset();
      for (int i = 0; i < fla_pkg::FREE_NODES; i++) fl_spare[i] = 1;
      for (int i = 0; i < fla_pkg::GRANT_ENTRIES; i++) gt_valid[i] = 0;
      fl_head = 0;
      fl_len = 0;
      regions_taken = 0;
      policy = fla_pkg::FIT_WORST;
   endfunction

   function automatic int spare_node();
      for (int i = 0; i < fla_pkg::FREE_NODES; i++) if (fl_spare[i]) return i;
      return -1;
   endfunction

   function automatic void push_slot(int n, logic [fla_pkg::ADDR_W-1:0] base,
                                     logic [fla_pkg::SIZE_W-1:0] bytes);
      fl_spare[n] = 0;
      fl_base[n] = base;
      fl_bytes[n] = bytes;
      fl_link[n] = fl_head;
      fl_head = n;
      fl_len++;
   endfunction

   function automatic response_type allocate_slot(logic [fla_pkg::SIZE_W-1:0] size);
      response_type r;
      int g, cur, prev, chosen, chosen_prev, n;
      bit found, at_head, take;
      logic [fla_pkg::SIZE_W-1:0] best, b, remain;
      logic [fla_pkg::ADDR_W-1:0] base;
      r = '0;
      g = -1;
      if (size > fla_pkg::SLOT_MAX) begin
         r.status = fla_pkg::ST_NO_REGION;
         return r;
      end
      for (int k = 0; k < fla_pkg::GRANT_ENTRIES; k++) if (!gt_valid[k]) begin
         g = k;
         break;
      end
      if (g < 0) begin
         r.status = fla_pkg::ST_POOL_FULL;
         return r;
      end
      cur = fl_head; prev = 0; chosen = 0; chosen_prev = 0;
      found = 0; at_head = 0; best = '0;
      for (int i = 0; i < fl_len; i++) begin
         b = fl_bytes[cur];
         take = 0;
         if (b >= size) begin
            if (policy == fla_pkg::FIT_BEST) take = !found || b < best;
            else if (policy == fla_pkg::FIT_WORST) take = b > best;
            else take = !found;
         end
         if (take) begin
            found = 1; chosen = cur; chosen_prev = prev; at_head = (i == 0); best = b;
         end
         prev = cur;
         cur = fl_link[cur];
      end
      if (!found) begin
         if (regions_taken >= fla_pkg::MAX_REGIONS) begin
            r.status = fla_pkg::ST_NO_REGION;
            return r;
         end
         n = spare_node();
         if (n < 0) begin
            r.status = fla_pkg::ST_POOL_FULL;
            return r;
         end
         push_slot(n, fla_pkg::ADDR_W'(regions_taken * fla_pkg::REGION_BYTES),
                   fla_pkg::SLOT_MAX);
         regions_taken++;
         r.added = 1;
         chosen = n;
         at_head = 1;
      end
      if (at_head) fl_head = fl_link[chosen];
      else fl_link[chosen_prev] = fl_link[chosen];
      fl_len--;
      base = fl_base[chosen];
      remain = fl_bytes[chosen] - size;
      gt_addr[g] = base + fla_pkg::ADDR_W'(fla_pkg::HDR_BYTES);
      gt_bytes[g] = size;
      gt_valid[g] = 1;
      r.addr = gt_addr[g];
      r.status = fla_pkg::ST_OK;
      live_addrs.push_back(gt_addr[g]);
      if (remain > fla_pkg::HDR_SIZE)
         push_slot(chosen, base + fla_pkg::ADDR_W'(fla_pkg::HDR_BYTES) + fla_pkg::ADDR_W'(size),
                   remain - fla_pkg::HDR_SIZE);
      else fl_spare[chosen] = 1;
      return r;
   endfunction

   function automatic response_type release_slot(logic [fla_pkg::ADDR_W-1:0] addr);
      response_type r;
      int g, n;
      r = '0;
      g = -1;
      for (int k = 0; k < fla_pkg::GRANT_ENTRIES; k++)
         if (gt_valid[k] && gt_addr[k] == addr) begin
            g = k;
            break;
         end
      if (g < 0) begin
         r.status = fla_pkg::ST_UNKNOWN;
         return r;
      end
      n = spare_node();
      if (n < 0) begin
         r.status = fla_pkg::ST_POOL_FULL;
         return r;
      end
      push_slot(n, addr - fla_pkg::ADDR_W'(fla_pkg::HDR_BYTES), gt_bytes[g]);
      gt_valid[g] = 0;
      r.status = fla_pkg::ST_OK;
      return r;
   endfunction

   function automatic request_type make_alloc(int bytes);
      request_type q;
      q.kind = fla_pkg::REQ_ALLOC;
      q.bytes = fla_pkg::SIZE_W'(bytes);
      q.addr = fla_pkg::ADDR_W'($urandom);
      return q;
   endfunction

   function automatic request_type make_free(logic [fla_pkg::ADDR_W-1:0] addr);
      request_type q;
      q.kind = fla_pkg::REQ_FREE;
      q.bytes = fla_pkg::SIZE_W'($urandom);
      q.addr = addr;
      return q;
   endfunction

   function automatic request_type random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         if ($urandom_range(0, 9) == 0) return make_alloc($urandom_range(0, 4095));
         if ($urandom_range(0, 9) == 0) return make_alloc($urandom_range(1000, 4080));
         return make_alloc(8 * $urandom_range(1, 40));
      end
      if (pick < 90 && live_addrs.size() > 0)
         return make_free(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
      return make_free(fla_pkg::ADDR_W'($urandom));
   endfunction

   // hold off between requests or responses: short mostly, sometimes long
   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.req_type <= fla_pkg::REQ_ALLOC;
         req_chan.alloc_bytes <= '0;
         req_chan.release_addr <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_chan.valid <= 1'b1;
            req_chan.req_type <= pending_requests[0].kind;
            req_chan.alloc_bytes <= pending_requests[0].bytes;
            req_chan.release_addr <= pending_requests[0].addr;
            void'(pending_requests.pop_front());
            req_gap <= random_gap();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         if (req_chan.req_type == fla_pkg::REQ_ALLOC)
            awaited_responses.push_back(allocate_slot(req_chan.alloc_bytes));
         else
            awaited_responses.push_back(release_slot(req_chan.release_addr));
         accepted <= accepted + 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!long_hold_done && accepted > 300) begin
            long_hold_done <= 1;
            rsp_hold <= 800;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_hold <= random_gap();
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: response with none expected: addr %h status %0d added %0d", $time,
                     rsp_chan.object_addr, rsp_chan.status, rsp_chan.region_added);
            failures++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_chan.object_addr !== want.addr) begin
               $display("%0t: object_addr expected %h actual %h", $time, want.addr,
                        rsp_chan.object_addr);
               failures++;
            end
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_chan.status);
               failures++;
            end
            if (rsp_chan.region_added !== want.added) begin
               $display("%0t: region_added expected %0d actual %0d", $time, want.added,
                        rsp_chan.region_added);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic drain();
      wait (pending_requests.size() == 0 && !req_chan.valid);
      wait (awaited_responses.size() == 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_policy(logic [1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      policy = value;
   endtask

   initial begin
      logic [1:0] policies [4];
      mirror_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // worst fit at reset
      pending_requests.push_back(make_alloc(0));
      pending_requests.push_back(make_alloc(8));
      pending_requests.push_back(make_alloc(4080));
      pending_requests.push_back(make_alloc(4081));
      pending_requests.push_back(make_alloc(4095));
      pending_requests.push_back(make_alloc(13));
      pending_requests.push_back(make_alloc(4064));
      pending_requests.push_back(make_free(fla_pkg::ADDR_W'(16)));
      pending_requests.push_back(make_free(fla_pkg::ADDR_W'(16)));
      pending_requests.push_back(make_free('1));
      pending_requests.push_back(make_free('0));
      pending_requests.push_back(make_alloc(100));
      drain();
      policies = '{fla_pkg::FIT_FIRST, fla_pkg::FIT_BEST, 2'd3, fla_pkg::FIT_WORST};
      for (int p = 0; p < 4; p++) begin
         write_policy(policies[p]);
         for (int i = 0; i < 3; i++) pending_requests.push_back(make_alloc(8 * (i + 1)));
         for (int i = 0; i < 130; i++) pending_requests.push_back(random_request());
         // fill the grant table with small objects
         if (p == 1) for (int i = 0; i < 70; i++) pending_requests.push_back(make_alloc(8));
         drain();
      end
      // exhaust regions with large allocations
      write_policy(fla_pkg::FIT_FIRST);
      for (int i = 0; i < 170; i++) begin
         if (live_addrs.size() > 40) begin
            pending_requests.push_back(make_free(live_addrs[0]));
            void'(live_addrs.pop_front());
         end
         pending_requests.push_back(make_alloc(4080));
      end
      drain();
      if (failures == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire

// File: free_list_fit_allocator_top.f
hw/rtl/fla_pkg.sv
hw/rtl/fla_ifs.sv
hw/rtl/fla_cell.sv
hw/rtl/fla_chain.sv
hw/rtl/free_list_fit_allocator_top.sv
test/free_list_fit_allocator_top_test.sv
